@@ design/pcu_pkg.sv @@
// ----------------------------------------------------------------------------
// pcu_pkg
// Shared types, codes and helpers for the pixel compositing unit.
// ----------------------------------------------------------------------------
package pcu_pkg;

  localparam int ChanW    = 8;
  localparam int PixW     = 32;
  localparam int NumLanes = 4;
  localparam int ModeW    = 3;
  localparam int CfgIdxW  = 3;
  localparam int ProdW    = 2 * ChanW;
  localparam int AlphaLane = 3;

  // mode register codes
  localparam logic [ModeW-1:0] MODE_COPY     = 3'd0;
  localparam logic [ModeW-1:0] MODE_OVER     = 3'd1;
  localparam logic [ModeW-1:0] MODE_GLOBAL   = 3'd2;
  localparam logic [ModeW-1:0] MODE_KEY_COPY = 3'd3;
  localparam logic [ModeW-1:0] MODE_KEY_OVER = 3'd4;
  localparam logic [ModeW-1:0] MODE_TINT     = 3'd5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_MODE         = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GLOBAL_ALPHA = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_COLOR    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_CHK_A    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TINT_COLOR   = 3'd4;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [ChanW-1:0] global_alpha;
    logic [PixW-1:0]  key_color;
    logic             key_checks_alpha;
    logic [PixW-1:0]  tint_color;
  } cfg_t;

  // one channel: addend + x0*p0/255 + x1*p1/255, saturated
  typedef struct packed {
    logic [ChanW-1:0] addend;
    logic [ChanW-1:0] x0;
    logic [ChanW-1:0] p0;
    logic [ChanW-1:0] x1;
    logic [ChanW-1:0] p1;
  } lane_op_t;

  typedef struct packed {
    logic            bypass;
    logic            written;
    logic [PixW-1:0] pixel;
  } pix_ctrl_t;

  // exact floor(x/255) for x up to 255*255
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    t = {1'b0, x} + (ProdW+1)'(x[ProdW-1:ChanW]) + (ProdW+1)'(1);
    return t[ProdW-1:ChanW];
  endfunction

endpackage

@@ design/pcu_front.sv @@
// ----------------------------------------------------------------------------
// pcu_front
// Mode decode, color key compare and per-channel operand selection.
// ----------------------------------------------------------------------------
module pcu_front import pcu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [PixW-1:0]       src_pixel,
  input  logic [PixW-1:0]       dst_pixel,
  input  cfg_t                  cfg,
  output logic                  valid_r,
  output pix_ctrl_t             ctrl_r,
  output lane_op_t [NumLanes-1:0] ops_r
);

  logic [ChanW-1:0]          sa;
  logic [ChanW-1:0]          ga;
  logic [ChanW-1:0]          ta;
  logic [PixW-1:0]           key_mask;
  logic                      key_hit;
  lane_op_t [NumLanes-1:0]   over_ops;
  lane_op_t [NumLanes-1:0]   global_ops;
  lane_op_t [NumLanes-1:0]   tint_ops;
  pix_ctrl_t                 over_ctrl;
  pix_ctrl_t                 global_ctrl;
  pix_ctrl_t                 skip_ctrl;
  pix_ctrl_t                 src_ctrl;
  pix_ctrl_t                 blend_ctrl;
  pix_ctrl_t                 ctrl_nxt;
  lane_op_t [NumLanes-1:0]   ops_nxt;

  always_comb begin
    sa       = src_pixel[PixW-1 -: ChanW];
    ga       = cfg.global_alpha;
    ta       = cfg.tint_color[PixW-1 -: ChanW];
    key_mask = cfg.key_checks_alpha ? {PixW{1'b1}} : {{ChanW{1'b0}}, {(PixW-ChanW){1'b1}}};
    key_hit  = ((src_pixel ^ cfg.key_color) & key_mask) == '0;

    for (int i = 0; i < NumLanes; i++) begin
      over_ops[i].addend = src_pixel[i*ChanW +: ChanW];
      over_ops[i].x0     = dst_pixel[i*ChanW +: ChanW];
      over_ops[i].p0     = ~sa;
      over_ops[i].x1     = '0;
      over_ops[i].p1     = '0;

      global_ops[i].addend = (i == AlphaLane) ? ga : src_pixel[i*ChanW +: ChanW];
      global_ops[i].x0     = dst_pixel[i*ChanW +: ChanW];
      global_ops[i].p0     = ~ga;
      global_ops[i].x1     = '0;
      global_ops[i].p1     = '0;

      if (i == AlphaLane) begin
        tint_ops[i].addend = sa;
        tint_ops[i].x0     = dst_pixel[i*ChanW +: ChanW];
        tint_ops[i].p0     = ~sa;
        tint_ops[i].x1     = '0;
        tint_ops[i].p1     = '0;
      end else begin
        tint_ops[i].addend = '0;
        tint_ops[i].x0     = src_pixel[i*ChanW +: ChanW];
        tint_ops[i].p0     = ta;
        tint_ops[i].x1     = cfg.tint_color[i*ChanW +: ChanW];
        tint_ops[i].p1     = ~ta;
      end
    end

    skip_ctrl  = '{bypass: 1'b1, written: 1'b0, pixel: dst_pixel};
    src_ctrl   = '{bypass: 1'b1, written: 1'b1, pixel: src_pixel};
    blend_ctrl = '{bypass: 1'b0, written: 1'b1, pixel: dst_pixel};

    // fully transparent or opaque source needs no arithmetic
    if (sa == '0) begin
      over_ctrl = '{bypass: 1'b1, written: 1'b1, pixel: dst_pixel};
    end else if (sa == '1) begin
      over_ctrl = src_ctrl;
    end else begin
      over_ctrl = blend_ctrl;
    end

    if (ga == '0) begin
      global_ctrl = '{bypass: 1'b1, written: 1'b1, pixel: dst_pixel};
    end else if (ga == '1) begin
      global_ctrl = src_ctrl;
    end else begin
      global_ctrl = blend_ctrl;
    end

    ctrl_nxt = skip_ctrl;
    ops_nxt  = over_ops;
    unique case (cfg.mode)
      MODE_COPY: begin
        ctrl_nxt = src_ctrl;
      end
      MODE_OVER: begin
        ctrl_nxt = over_ctrl;
      end
      MODE_GLOBAL: begin
        ctrl_nxt = global_ctrl;
        ops_nxt  = global_ops;
      end
      MODE_KEY_COPY: begin
        ctrl_nxt = key_hit ? skip_ctrl : src_ctrl;
      end
      MODE_KEY_OVER: begin
        ctrl_nxt = key_hit ? skip_ctrl : over_ctrl;
      end
      MODE_TINT: begin
        ctrl_nxt = (sa == '0) ? skip_ctrl : blend_ctrl;
        ops_nxt  = tint_ops;
      end
      default: begin
        ctrl_nxt = skip_ctrl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctrl_r <= ctrl_nxt;
    ops_r  <= ops_nxt;
  end

endmodule

@@ design/pcu_lane.sv @@
// ----------------------------------------------------------------------------
// pcu_lane
// One color channel: multiply, divide by 255, then add and saturate.
// ----------------------------------------------------------------------------
module pcu_lane import pcu_pkg::*; (
  input  logic             clk,
  input  lane_op_t         op,
  output logic [ChanW-1:0] chan_r
);

  logic [ProdW-1:0]  prod0_r;
  logic [ProdW-1:0]  prod1_r;
  logic [ChanW-1:0]  add_s2_r;
  logic [ChanW-1:0]  q0_r;
  logic [ChanW-1:0]  q1_r;
  logic [ChanW-1:0]  add_s3_r;
  logic [ChanW+1:0]  sum;
  logic [ChanW-1:0]  chan_nxt;

  always_comb begin
    sum      = (ChanW+2)'(add_s3_r) + (ChanW+2)'(q0_r) + (ChanW+2)'(q1_r);
    chan_nxt = (sum[ChanW+1:ChanW] != '0) ? {ChanW{1'b1}} : sum[ChanW-1:0];
  end

  always_ff @(posedge clk) begin
    prod0_r  <= op.x0 * op.p0;
    prod1_r  <= op.x1 * op.p1;
    add_s2_r <= op.addend;
    q0_r     <= div255(prod0_r);
    q1_r     <= div255(prod1_r);
    add_s3_r <= add_s2_r;
    chan_r   <= chan_nxt;
  end

endmodule

@@ design/pixel_compositing_unit.sv @@
// ----------------------------------------------------------------------------
// pixel_compositing_unit
// ARGB8888 blit compositing: copy, per-pixel over, global alpha, color key
// and tint.
// ----------------------------------------------------------------------------
// Takes one source/destination pixel pair per clock (busy never rises) and
// returns the new destination pixel with out_valid high for one cycle,
// after one stage of decode and key compare, then multiply, divide by 255
// and add/saturate in each of the four channel lanes. Results
// come out in input order and cannot be held off, so the receiver must take
// each one in the cycle it appears. Write configuration only while no pixel
// is in flight.
module pixel_compositing_unit import pcu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [PixW-1:0]    in_src_pixel,
  input  logic [PixW-1:0]    in_dst_pixel,
  output logic               out_valid,
  output logic [PixW-1:0]    out_result_pixel,
  output logic               out_dst_written,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [PixW-1:0]    cfg_wdata
);

  cfg_t                    cfg_r;
  logic                    v1;
  pix_ctrl_t               ctrl1;
  lane_op_t [NumLanes-1:0] ops1;
  logic                    v2_r, v3_r, v4_r;
  pix_ctrl_t               ctrl2_r, ctrl3_r, ctrl4_r;
  logic [PixW-1:0]         blend_pixel;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode             <= MODE_COPY;
      cfg_r.global_alpha     <= {ChanW{1'b1}};
      cfg_r.key_color        <= '0;
      cfg_r.key_checks_alpha <= 1'b0;
      cfg_r.tint_color       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:         cfg_r.mode             <= cfg_wdata[ModeW-1:0];
        REG_GLOBAL_ALPHA: cfg_r.global_alpha     <= cfg_wdata[ChanW-1:0];
        REG_KEY_COLOR:    cfg_r.key_color        <= cfg_wdata;
        REG_KEY_CHK_A:    cfg_r.key_checks_alpha <= cfg_wdata[0];
        REG_TINT_COLOR:   cfg_r.tint_color       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pcu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .src_pixel (in_src_pixel),
    .dst_pixel (in_dst_pixel),
    .cfg       (cfg_r),
    .valid_r   (v1),
    .ctrl_r    (ctrl1),
    .ops_r     (ops1)
  );

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    pcu_lane u_lane (
      .clk    (clk),
      .op     (ops1[i]),
      .chan_r (blend_pixel[i*ChanW +: ChanW])
    );
  end

  // control travels alongside the lane pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v2_r <= v1;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    ctrl2_r <= ctrl1;
    ctrl3_r <= ctrl2_r;
    ctrl4_r <= ctrl3_r;
  end

  assign out_valid        = v4_r;
  assign out_result_pixel = ctrl4_r.bypass ? ctrl4_r.pixel : blend_pixel;
  assign out_dst_written  = ctrl4_r.written;

endmodule
